// ===== design/cartridge_bank_register_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// cartridge bank register decoder assertion macros
// shared assertion forms for the decoder modules
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_REGISTER_DECODER_TOP_MACROS_SVH
`define CARTRIDGE_BANK_REGISTER_DECODER_TOP_MACROS_SVH

// clocked check, skipped while reset is high
`define CBRD_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define CBRD_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/cbrd_pkg.sv =====
// ----------------------------------------------------------------------------
// cbrd_pkg
// types and codes shared by the cartridge bank register decoder
// ----------------------------------------------------------------------------
`default_nettype none

package cbrd_pkg;

   localparam int unsigned ADDR_W     = 15;
   localparam int unsigned VALUE_W    = 8;
   localparam int unsigned ROM_BANK_W = 9;
   localparam int unsigned RAM_BANK_W = 4;
   localparam int unsigned RTC_REG_W  = 4;
   localparam int unsigned KIND_W     = 3;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 3;
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 24;

   // controller kinds
   localparam logic [KIND_W-1:0] KIND_NONE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MBC1 = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MBC2 = 3'd2;
   localparam logic [KIND_W-1:0] KIND_MBC3 = 3'd3;
   localparam logic [KIND_W-1:0] KIND_MBC5 = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KIND    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_RAM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_RTC = 2'd2;

   // address quarter decoded from bits 14:13
   localparam logic [1:0] ACT_RAM_EN   = 2'd0;
   localparam logic [1:0] ACT_ROM_LOW  = 2'd1;
   localparam logic [1:0] ACT_UPPER    = 2'd2;
   localparam logic [1:0] ACT_MODE     = 2'd3;

   typedef enum logic [1:0] {
      WIN_UNMAPPED = 2'd0,
      WIN_RAM      = 2'd1,
      WIN_RTC      = 2'd2
   } win_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              has_ram;
      logic              has_rtc;
   } cfg_type;

   typedef struct packed {
      logic                  rtc_latch_pulse;
      logic [RTC_REG_W-1:0]  rtc_register;
      win_type               window_target;
      logic [RAM_BANK_W-1:0] ram_bank;
      logic [ROM_BANK_W-1:0] rom_bank;
   } map_type;

endpackage

`default_nettype wire

// ===== design/cartridge_bank_register_decoder_top.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_register_decoder_top
// bank register decoder for mbc1/mbc2/mbc3/mbc5 style cartridge writes
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  address, value
//  rsp      out        rsp_tvalid/rsp_tready  rom_bank, ram_bank, window, rtc reg, pulse
//  csr      in         csr_valid/csr_ready    register index, write data
//
//  one item per cycle sustained while rsp is not stalled; an accepted req reaches rsp_tvalid
//  through the input register, then the bank update into the result register
//  reset loads the default config, bank state and both valid flags
//  a stalled rsp holds the result; the input register still fills behind it
// ----------------------------------------------------------------------------
`default_nettype none

module cartridge_bank_register_decoder_top
   import cbrd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // address[14:0], value[22:15], zero pad
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,  // rom_bank[8:0], ram_bank[12:9],
                                                  // window_target[14:13], rtc_register[18:15],
                                                  // rtc_latch_pulse[19], zero pad
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

`include "cartridge_bank_register_decoder_top_macros.svh"

   cfg_type              cfg;
   map_type              map_next;
   map_type              rsp_map_ff;
   logic                 in_valid_ff;
   logic [ADDR_W-1:0]    in_addr_ff;
   logic [VALUE_W-1:0]   in_value_ff;
   logic                 rsp_valid_ff;
   logic                 out_ready;
   logic                 advance;

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - $bits(map_type))'(0), rsp_map_ff};

   cbrd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cbrd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .step     (advance),
      .address  (in_addr_ff),
      .value    (in_value_ff),
      .map_next (map_next)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_addr_ff  <= req_tdata[ADDR_W-1:0];
         in_value_ff <= req_tdata[ADDR_W+VALUE_W-1:ADDR_W];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_map_ff <= map_next;
      end
   end

   `CBRD_ASSERT(a_advance_gives_rsp, clock, reset, advance |=> rsp_valid_ff, "result lost after update")
   `CBRD_ASSERT(a_blocked_item_held, clock, reset, (in_valid_ff && !out_ready) |=> (in_valid_ff && $stable(in_addr_ff) && $stable(in_value_ff)), "stalled item dropped")
   `CBRD_ASSERT(a_not_ready_full, clock, reset, !req_tready |-> (in_valid_ff && rsp_valid_ff), "input stalled with room")

endmodule

`default_nettype wire

// ===== design/cbrd_csr.sv =====
// ----------------------------------------------------------------------------
// cbrd_csr
// configuration registers: controller kind, ram present, rtc present
// ----------------------------------------------------------------------------
`default_nettype none

module cbrd_csr
   import cbrd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output      cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_KIND:    cfg_in.kind    = csr_wdata[KIND_W-1:0];
            CSR_HAS_RAM: cfg_in.has_ram = csr_wdata[0];
            CSR_HAS_RTC: cfg_in.has_rtc = csr_wdata[0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kind    <= KIND_MBC1;
         cfg_ff.has_ram <= 1'b1;
         cfg_ff.has_rtc <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/cbrd_core.sv =====
// ----------------------------------------------------------------------------
// cbrd_core
// bank register state and the per-write update for each controller kind
// ----------------------------------------------------------------------------
`default_nettype none

module cbrd_core
   import cbrd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               step,
   input  wire logic [ADDR_W-1:0]  address,
   input  wire logic [VALUE_W-1:0] value,
   output map_type                 map_next
);

`include "cartridge_bank_register_decoder_top_macros.svh"

   logic [ROM_BANK_W-1:0] rom_bank_ff, rom_bank_in;
   logic [RAM_BANK_W-1:0] ram_bank_ff, ram_bank_in;
   win_type               window_ff, window_in;
   logic [RTC_REG_W-1:0]  rtc_sel_ff, rtc_sel_in;
   logic                  mode_ff, mode_in;
   logic                  latch_ff, latch_in;
   logic                  pulse;

   logic [1:0]            action;
   logic                  ram_present;
   logic [3:0]            nib;
   logic [4:0]            low5;
   logic [ROM_BANK_W-1:0] cur;

   function automatic logic [ROM_BANK_W-1:0] nonzero_bank(input logic [ROM_BANK_W-1:0] b);
      return (b == '0) ? ROM_BANK_W'(1) : b;
   endfunction

   assign action      = address[14:13];
   assign ram_present = cfg.has_ram || (cfg.kind == KIND_MBC2);
   assign nib         = value[3:0];
   assign low5        = (value[4:0] == 5'd0) ? 5'd1 : value[4:0];
   assign cur         = mode_ff ? {4'd0, rom_bank_ff[4:0]} : rom_bank_ff;

   always_comb begin
      rom_bank_in = rom_bank_ff;
      ram_bank_in = ram_bank_ff;
      window_in   = window_ff;
      rtc_sel_in  = rtc_sel_ff;
      mode_in     = mode_ff;
      latch_in    = latch_ff;
      pulse       = 1'b0;
      case (cfg.kind)
         KIND_MBC1: begin
            case (action)
               ACT_RAM_EN: begin
                  if (nib == 4'ha) begin
                     if (ram_present) window_in = WIN_RAM;
                  end else begin
                     window_in = WIN_UNMAPPED;
                  end
               end
               ACT_ROM_LOW: rom_bank_in = {1'b0, cur[7:5], low5};
               ACT_UPPER: begin
                  if (mode_ff) begin
                     if (ram_present) ram_bank_in = {2'd0, value[1:0]};
                  end else begin
                     rom_bank_in = nonzero_bank({2'd0, value[1:0], rom_bank_ff[4:0]});
                  end
               end
               default: mode_in = value[0];
            endcase
         end
         KIND_MBC2: begin
            case (action)
               ACT_RAM_EN: begin
                  if (!address[8]) begin
                     if (nib == 4'ha) begin
                        window_in = WIN_RAM;
                     end else begin
                        window_in = WIN_UNMAPPED;
                     end
                  end
               end
               ACT_ROM_LOW: begin
                  if (address[8]) rom_bank_in = nonzero_bank({5'd0, value[3:0]});
               end
               default: ;
            endcase
         end
         KIND_MBC3: begin
            case (action)
               ACT_RAM_EN: begin
                  // only a zero nibble unmaps here
                  if (nib == 4'ha) begin
                     if (ram_present) window_in = WIN_RAM;
                  end else if (nib == 4'h0) begin
                     window_in = WIN_UNMAPPED;
                  end
               end
               ACT_ROM_LOW: rom_bank_in = nonzero_bank({2'd0, value[6:0]});
               ACT_UPPER: begin
                  if (value < 8'h04 && ram_present) begin
                     ram_bank_in = value[3:0];
                     window_in   = WIN_RAM;
                  end else if (value >= 8'h08 && value < 8'h0d && cfg.has_rtc) begin
                     rtc_sel_in = value[3:0];
                     window_in  = WIN_RTC;
                  end
               end
               default: begin
                  pulse    = !latch_ff && (value == 8'h01) && cfg.has_rtc;
                  latch_in = (value != 8'h00);
               end
            endcase
         end
         KIND_MBC5: begin
            case (action)
               ACT_RAM_EN: begin
                  if (nib == 4'ha) begin
                     if (ram_present) window_in = WIN_RAM;
                  end else begin
                     window_in = WIN_UNMAPPED;
                  end
               end
               ACT_ROM_LOW: begin
                  if (address[12]) begin
                     rom_bank_in = nonzero_bank({value[0], rom_bank_ff[7:0]});
                  end else begin
                     rom_bank_in = nonzero_bank({rom_bank_ff[8], value});
                  end
               end
               ACT_UPPER: begin
                  if (value < 8'h10 && ram_present) begin
                     ram_bank_in = value[3:0];
                     window_in   = WIN_RAM;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bank_ff <= ROM_BANK_W'(1);
         ram_bank_ff <= '0;
         window_ff   <= WIN_RAM;
         rtc_sel_ff  <= RTC_REG_W'(8);
         mode_ff     <= 1'b0;
         latch_ff    <= 1'b0;
      end else if (step) begin
         rom_bank_ff <= rom_bank_in;
         ram_bank_ff <= ram_bank_in;
         window_ff   <= window_in;
         rtc_sel_ff  <= rtc_sel_in;
         mode_ff     <= mode_in;
         latch_ff    <= latch_in;
      end
   end

   always_comb begin
      map_next.rom_bank        = rom_bank_in;
      map_next.ram_bank        = ram_bank_in;
      map_next.window_target   = window_in;
      map_next.rtc_register    = rtc_sel_in;
      map_next.rtc_latch_pulse = pulse;
   end

   `CBRD_ASSERT(a_rom_bank_nonzero, clock, reset, rom_bank_ff != '0, "rom bank is zero")
   `CBRD_ASSERT(a_pulse_mbc3_rtc, clock, reset, pulse |-> (cfg.kind == KIND_MBC3 && cfg.has_rtc), "latch pulse outside mbc3 with rtc")
   `CBRD_ASSERT(a_pulse_sets_history, clock, reset, (step && pulse) |=> latch_ff, "latch history not set after pulse")

endmodule

`default_nettype wire

// ===== tb/sv/tb_cartridge_bank_register_decoder_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cartridge_bank_register_decoder_top
// drives cpu writes into the bank decoder under a range of controller kinds
// and ram/rtc options, predicts the bank mapping after each write and checks
// every returned item in order, with random idle bursts on both streams
// ----------------------------------------------------------------------------

module tb_cartridge_bank_register_decoder_top;
   import cbrd_pkg::*;

   localparam int unsigned CLOCK_HALF      = 4;
   localparam int unsigned RESET_CYCLES    = 12;
   localparam int unsigned CYCLE_LIMIT     = 500000;
   localparam int unsigned PHASES          = 14;
   localparam int unsigned ITEMS_PER_PHASE = 75;
   localparam int unsigned SETTLE_CYCLES   = 8;

   // kinds outside the known set, the block ignores writes under them
   localparam logic [KIND_W-1:0] KIND_UNKNOWN_LO = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN_HI = 3'd7;
   localparam logic [3:0]        RAM_ENABLE_KEY  = 4'hA;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // address[14:0], value[22:15], zero pad
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // rom_bank[8:0], ram_bank[12:9],
                                           // window_target[14:13], rtc_register[18:15],
                                           // rtc_latch_pulse[19], zero pad
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int unsigned cycle_count = 0;
   int unsigned req_gap_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned stall_left = 0;

   cfg_type phase_plan [PHASES] = '{
      {KIND_MBC1, 1'b1, 1'b0},
      {KIND_MBC1, 1'b0, 1'b1},
      {KIND_MBC2, 1'b0, 1'b0},
      {KIND_MBC2, 1'b1, 1'b1},
      {KIND_MBC3, 1'b1, 1'b1},
      {KIND_MBC3, 1'b0, 1'b1},
      {KIND_MBC3, 1'b1, 1'b0},
      {KIND_MBC3, 1'b0, 1'b0},
      {KIND_MBC5, 1'b1, 1'b0},
      {KIND_MBC5, 1'b0, 1'b1},
      {KIND_NONE, 1'b1, 1'b1},
      {KIND_UNKNOWN_HI, 1'b0, 1'b0},
      {KIND_MBC3, 1'b1, 1'b1},
      {KIND_MBC1, 1'b1, 1'b0}
   };

   class bank_map_scoreboard;
      cfg_type               cfg;
      logic [ROM_BANK_W-1:0] rom_bank;
      logic [RAM_BANK_W-1:0] ram_bank;
      win_type               window;
      logic [RTC_REG_W-1:0]  rtc_sel;
      logic                  ram_mode;
      logic                  latch_nonzero;
      map_type               expected_maps [$];
      int unsigned           fail_count;

      function new();
         cfg           = {KIND_MBC1, 1'b1, 1'b0};
         rom_bank      = 9'd1;
         ram_bank      = '0;
         window        = WIN_RAM;
         rtc_sel       = 4'd8;
         ram_mode      = 1'b0;
         latch_nonzero = 1'b0;
         fail_count    = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_KIND:    cfg.kind    = data;
            CSR_HAS_RAM: cfg.has_ram = data[0];
            CSR_HAS_RTC: cfg.has_rtc = data[0];
            default: ;
         endcase
      endfunction

      function bit ram_present();
         return cfg.has_ram || cfg.kind == KIND_MBC2;
      endfunction

      function logic [ROM_BANK_W-1:0] nonzero_bank(int unsigned b);
         logic [ROM_BANK_W-1:0] masked;
         masked = b[ROM_BANK_W-1:0];
         return (masked == 0) ? 9'd1 : masked;
      endfunction

      // 0xA maps ram when present, other nibbles unmap (mbc3: only zero)
      function void enable_window(logic [VALUE_W-1:0] val, bit only_zero_unmaps);
         if (val[3:0] == RAM_ENABLE_KEY) begin
            if (ram_present()) window = WIN_RAM;
         end else if (!only_zero_unmaps || val[3:0] == 4'd0) begin
            window = WIN_UNMAPPED;
         end
      endfunction

      function void note_write(logic [ADDR_W-1:0] addr, logic [VALUE_W-1:0] val);
         logic [1:0]  quarter;
         int unsigned low;
         int unsigned cur;
         map_type     m;
         quarter = addr[14:13];
         m.rtc_latch_pulse = 1'b0;
         case (cfg.kind)
            KIND_MBC1: begin
               case (quarter)
                  ACT_RAM_EN: enable_window(val, 1'b0);
                  ACT_ROM_LOW: begin
                     low = val & 8'h1f;
                     if (low == 0) low = 1;
                     cur = rom_bank;
                     if (ram_mode) cur = cur & 'h1f;
                     rom_bank = nonzero_bank((cur & 'he0) | low);
                  end
                  ACT_UPPER: begin
                     if (ram_mode) begin
                        if (ram_present()) ram_bank = {2'b00, val[1:0]};
                     end else begin
                        rom_bank = nonzero_bank((rom_bank & 'h1f) | (int'(val[1:0]) << 5));
                     end
                  end
                  default: ram_mode = val[0];
               endcase
            end
            KIND_MBC2: begin
               if (quarter == ACT_RAM_EN && !addr[8]) enable_window(val, 1'b0);
               else if (quarter == ACT_ROM_LOW && addr[8]) rom_bank = nonzero_bank(val[3:0]);
            end
            KIND_MBC3: begin
               case (quarter)
                  ACT_RAM_EN:  enable_window(val, 1'b1);
                  ACT_ROM_LOW: rom_bank = nonzero_bank(val & 8'h7f);
                  ACT_UPPER: begin
                     if (val < 4 && ram_present()) begin
                        ram_bank = val[3:0];
                        window   = WIN_RAM;
                     end else if (val >= 8 && val < 13 && cfg.has_rtc) begin
                        rtc_sel = val[3:0];
                        window  = WIN_RTC;
                     end
                  end
                  default: begin
                     // latch fires on a 0 then 1 sequence
                     if (!latch_nonzero && val == 1 && cfg.has_rtc) m.rtc_latch_pulse = 1'b1;
                     latch_nonzero = (val != 0);
                  end
               endcase
            end
            KIND_MBC5: begin
               case (quarter)
                  ACT_RAM_EN: enable_window(val, 1'b0);
                  ACT_ROM_LOW: begin
                     if (addr[12]) rom_bank = nonzero_bank({val[0], rom_bank[7:0]});
                     else rom_bank = nonzero_bank({rom_bank[8], val});
                  end
                  ACT_UPPER: begin
                     if (val < 16 && ram_present()) begin
                        ram_bank = val[3:0];
                        window   = WIN_RAM;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
         m.rom_bank      = rom_bank;
         m.ram_bank      = ram_bank;
         m.window_target = window;
         m.rtc_register  = rtc_sel;
         expected_maps.push_back(m);
      endfunction

      function void field_error(string name, logic [8:0] want, logic [8:0] got);
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      endfunction

      function void check_map(logic [RSP_DATA_W-1:0] word);
         map_type got;
         map_type want;
         got = map_type'(word[$bits(map_type)-1:0]);
         if (expected_maps.size() == 0) begin
            $error("result item with nothing expected, rsp_tdata %h", word);
            fail_count++;
            return;
         end
         want = expected_maps.pop_front();
         if (got.rom_bank !== want.rom_bank)
            field_error("rom_bank", want.rom_bank, got.rom_bank);
         if (got.ram_bank !== want.ram_bank)
            field_error("ram_bank", want.ram_bank, got.ram_bank);
         if (got.window_target !== want.window_target)
            field_error("window_target", want.window_target, got.window_target);
         if (got.rtc_register !== want.rtc_register)
            field_error("rtc_register", want.rtc_register, got.rtc_register);
         if (got.rtc_latch_pulse !== want.rtc_latch_pulse)
            field_error("rtc_latch_pulse", want.rtc_latch_pulse, got.rtc_latch_pulse);
      endfunction
   endclass

   bank_map_scoreboard sb;

   cartridge_bank_register_decoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLOCK_HALF) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_cartridge_bank_register_decoder_top: FAIL");
         $finish;
      end
   end

   // result side: check accepted items, stall in bursts of random length
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_map(rsp_tdata);
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct) begin
         stall_left <= $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_write(input logic [ADDR_W-1:0] addr, input logic [VALUE_W-1:0] val);
      if (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, val, addr};
      do @(posedge clock); while (!req_tready);
      sb.note_write(addr, val);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
   endtask

   // registers change only once every item in flight has come back
   task automatic configure(input cfg_type c);
      req_tvalid <= 1'b0;
      while (sb.expected_maps.size() != 0) @(posedge clock);
      write_reg(CSR_KIND, c.kind);
      write_reg(CSR_HAS_RAM, {2'b00, c.has_ram});
      write_reg(CSR_HAS_RTC, {2'b00, c.has_rtc});
      csr_valid <= 1'b0;
   endtask

   // mostly values that hit the decode cases, with plain random bytes mixed in
   task automatic random_write(output logic [ADDR_W-1:0] addr, output logic [VALUE_W-1:0] val);
      addr = ADDR_W'($urandom);
      case ($urandom_range(0, 7))
         0, 1: val = VALUE_W'($urandom);
         2:    val = {4'($urandom), RAM_ENABLE_KEY};
         3:    val = {4'($urandom), 4'd0};
         4:    val = VALUE_W'($urandom_range(0, 3));
         5:    val = VALUE_W'($urandom_range(8, 12));
         6:    val = VALUE_W'($urandom_range(0, 1));
         default: val = VALUE_W'($urandom_range(0, 15));
      endcase
   endtask

   initial begin
      logic [ADDR_W-1:0]  addr;
      logic [VALUE_W-1:0] val;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // mbc1 from reset settings: enable, bank zero, upper bits, ram mode
      send_write(15'h0000, 8'h00);
      send_write(15'h0000, 8'h0A);
      send_write(15'h2000, 8'h00);
      send_write(15'h3FFF, 8'hFF);
      send_write(15'h4000, 8'h03);
      send_write(15'h6000, 8'h01);
      send_write(15'h2000, 8'h20);
      send_write(15'h5FFF, 8'h03);
      send_write(15'h7FFF, 8'h00);
      // mbc2: address bit 8 gates both registers, ram always present
      configure({KIND_MBC2, 1'b0, 1'b0});
      send_write(15'h0100, 8'h0A);
      send_write(15'h0000, 8'h0A);
      send_write(15'h2100, 8'h00);
      send_write(15'h2100, 8'hFF);
      send_write(15'h4000, 8'hFF);
      // mbc3 with rtc: register select, ram select, ignored nibble, latch
      configure({KIND_MBC3, 1'b1, 1'b1});
      send_write(15'h4000, 8'h0C);
      send_write(15'h4000, 8'h03);
      send_write(15'h0000, 8'h05);
      send_write(15'h6000, 8'h00);
      send_write(15'h6000, 8'h01);
      send_write(15'h2000, 8'h80);
      // mbc5: ninth rom bit, full low byte, top ram bank, unmap
      configure({KIND_MBC5, 1'b1, 1'b0});
      send_write(15'h3000, 8'h01);
      send_write(15'h2000, 8'h00);
      send_write(15'h4000, 8'h0F);
      send_write(15'h0000, 8'hFF);
      configure({KIND_UNKNOWN_LO, 1'b1, 1'b0});
      send_write(15'h2000, 8'h05);

      for (int p = 0; p < PHASES; p++) begin
         configure(phase_plan[p]);
         if (p >= PHASES - 2) begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end else begin
            req_gap_pct   = $urandom_range(0, 3) * 12;
            rsp_stall_pct = $urandom_range(0, 3) * 12;
         end
         repeat (ITEMS_PER_PHASE) begin
            random_write(addr, val);
            send_write(addr, val);
         end
      end

      req_tvalid <= 1'b0;
      while (sb.expected_maps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("tb_cartridge_bank_register_decoder_top: PASS");
      end else begin
         $display("tb_cartridge_bank_register_decoder_top: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/cbrd_pkg.sv
design/cbrd_csr.sv
design/cbrd_core.sv
design/cartridge_bank_register_decoder_top.sv
tb/sv/tb_cartridge_bank_register_decoder_top.sv
